// ===== hdl/bmsirq_pkg.sv =====
`timescale 1ns / 1ps

package bmsirq_pkg;

	// Item field widths
	localparam int CMD_W      = 2;
	localparam int BUS_ADDR_W = 16;
	localparam int DATA_W     = 8;
	localparam int MAP_ADDR_W = 19;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PRG_BANK_MASK = 2'd0,
		CFG_CHR_BANK_MASK = 2'd1,
		CFG_ALT_IRQ_MODE  = 2'd2,
		CFG_FOUR_SCREEN   = 2'd3
	} cfg_index_t;

	// Item commands
	localparam logic [CMD_W-1:0] CMD_REG_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CPU_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PPU_READ  = 2'd2;

	// CPU register decode
	localparam logic [BUS_ADDR_W-1:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [BUS_ADDR_W-1:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [BUS_ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [BUS_ADDR_W-1:0] REG_MIRRORING   = 16'hA000;
	localparam logic [BUS_ADDR_W-1:0] REG_IRQ_LATCH   = 16'hC000;
	localparam logic [BUS_ADDR_W-1:0] REG_IRQ_CLEAR   = 16'hC001;
	localparam logic [BUS_ADDR_W-1:0] REG_IRQ_DISABLE = 16'hE000;
	localparam logic [BUS_ADDR_W-1:0] REG_IRQ_ENABLE  = 16'hE001;

	// Bank select targets
	localparam logic [2:0] BSEL_CHR_2K_0 = 3'd0;
	localparam logic [2:0] BSEL_CHR_2K_1 = 3'd1;
	localparam logic [2:0] BSEL_CHR_1K_0 = 3'd2;
	localparam logic [2:0] BSEL_CHR_1K_1 = 3'd3;
	localparam logic [2:0] BSEL_CHR_1K_2 = 3'd4;
	localparam logic [2:0] BSEL_CHR_1K_3 = 3'd5;
	localparam logic [2:0] BSEL_PRG_A    = 3'd6;

	// Fixed PRG banks and 2 KB pair forming
	localparam logic [7:0] PRG_SECOND_LAST = 8'hFE;
	localparam logic [7:0] PRG_LAST        = 8'hFF;
	localparam logic [7:0] PAIR_EVEN_MASK  = 8'hFE;
	localparam logic [7:0] PAIR_ODD_SET    = 8'h01;

	typedef logic [7:0] chr_bank_t;

endpackage

// ===== hdl/bmsirq_in_if.sv =====
`timescale 1ns / 1ps

interface bmsirq_in_if
	import bmsirq_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [BUS_ADDR_W-1:0] bus_address;
	logic [DATA_W-1:0]     write_data;

	modport source (output valid, output cmd, output bus_address, output write_data,
		input ready);
	modport sink (input valid, input cmd, input bus_address, input write_data,
		output ready);
endinterface

// ===== hdl/bmsirq_out_if.sv =====
`timescale 1ns / 1ps

interface bmsirq_out_if
	import bmsirq_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [MAP_ADDR_W-1:0] mapped_address;
	logic                  irq_pending;
	logic                  mirror_horizontal;

	modport source (output valid, output mapped_address, output irq_pending,
		output mirror_horizontal, input ready);
	modport sink (input valid, input mapped_address, input irq_pending,
		input mirror_horizontal, output ready);
endinterface

// ===== hdl/bank_mapper_with_scanline_irq.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; each item reads and
// updates the bank and IRQ registers in a single pass between the input and result registers.
// Reset (arst_n low, asynchronous): bank, IRQ and configuration registers return to
// their power-on values at once; both pipeline stages empty. No clearing pass.

module bank_mapper_with_scanline_irq
	import bmsirq_pkg::*;
#(
	parameter int PRG_ADDR_BITS = 19,
	parameter int CHR_ADDR_BITS = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bmsirq_in_if.sink              in_ch,
	bmsirq_out_if.source           out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [MAP_ADDR_W-1:0] PRG_KEEP = (PRG_ADDR_BITS >= MAP_ADDR_W) ?
		{MAP_ADDR_W{1'b1}} : MAP_ADDR_W'((32'd1 << PRG_ADDR_BITS) - 32'd1);
	localparam logic [MAP_ADDR_W-1:0] CHR_KEEP = (CHR_ADDR_BITS >= MAP_ADDR_W) ?
		{MAP_ADDR_W{1'b1}} : MAP_ADDR_W'((32'd1 << CHR_ADDR_BITS) - 32'd1);

	// Configuration registers
	logic [5:0] prg_bank_mask_q;
	logic [7:0] chr_bank_mask_q;
	logic       alt_irq_mode_q;
	logic       four_screen_q;

	// Mapper state
	chr_bank_t  chr_banks_q [8];
	logic [7:0] prg_bank_a_q;
	logic [7:0] prg_bank_b_q;
	logic [2:0] bank_select_q;
	logic       chr_invert_q;
	logic       prg_swap_q;
	logic [7:0] irq_counter_q;
	logic [7:0] irq_reload_q;
	logic       irq_enable_q;
	logic       reload_request_q;
	logic       prev_a12_q;
	logic       irq_flag_q;
	logic       mirroring_q;

	// Next state
	chr_bank_t  chr_banks_d [8];
	logic [7:0] prg_bank_a_d;
	logic [7:0] prg_bank_b_d;
	logic [2:0] bank_select_d;
	logic       chr_invert_d;
	logic       prg_swap_d;
	logic [7:0] irq_counter_d;
	logic [7:0] irq_reload_d;
	logic       irq_enable_d;
	logic       reload_request_d;
	logic       prev_a12_d;
	logic       irq_flag_d;
	logic       mirroring_d;

	// Input stage
	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [BUS_ADDR_W-1:0] bus_address_s1;
	logic [DATA_W-1:0]     write_data_s1;

	// Result stage
	logic                  valid_s2;
	logic [MAP_ADDR_W-1:0] mapped_address_s2;
	logic                  irq_pending_s2;
	logic                  mirror_horizontal_s2;

	logic                  advance;
	logic                  process;
	logic [MAP_ADDR_W-1:0] mapped_d;
	logic [BUS_ADDR_W-1:0] reg_sel;
	logic [7:0]            prg_bank;
	logic [5:0]            prg_bank_m;
	logic [2:0]            chr_slot;
	logic [7:0]            chr_bank_m;
	logic [7:0]            counter_next;
	logic                  a12_rise;

	// Handshake: the result register frees the input stage
	assign advance      = !valid_s2 || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || advance;
	assign process      = valid_s1 && advance;

	assign out_ch.valid             = valid_s2;
	assign out_ch.mapped_address    = mapped_address_s2;
	assign out_ch.irq_pending       = irq_pending_s2;
	assign out_ch.mirror_horizontal = mirror_horizontal_s2;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_mask_q <= 6'd63;
			chr_bank_mask_q <= 8'd255;
			alt_irq_mode_q  <= 1'b0;
			four_screen_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PRG_BANK_MASK: prg_bank_mask_q <= cfg_data[5:0];
				CFG_CHR_BANK_MASK: chr_bank_mask_q <= cfg_data;
				CFG_ALT_IRQ_MODE:  alt_irq_mode_q  <= cfg_data[0];
				CFG_FOUR_SCREEN:   four_screen_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cmd_s1         <= in_ch.cmd;
			bus_address_s1 <= in_ch.bus_address;
			write_data_s1  <= in_ch.write_data;
		end
	end

	// Translate addresses
	assign reg_sel = bus_address_s1 & REG_DECODE_MASK;

	always_comb begin
		case (bus_address_s1[14:13])
			2'd0:    prg_bank = prg_swap_q ? (PRG_SECOND_LAST & {2'b00, prg_bank_mask_q})
				: prg_bank_a_q;
			2'd1:    prg_bank = prg_bank_b_q;
			2'd2:    prg_bank = prg_swap_q ? prg_bank_a_q
				: (PRG_SECOND_LAST & {2'b00, prg_bank_mask_q});
			default: prg_bank = PRG_LAST & {2'b00, prg_bank_mask_q};
		endcase
	end

	assign prg_bank_m = prg_bank[5:0] & prg_bank_mask_q;
	assign chr_slot   = bus_address_s1[12:10] ^ {chr_invert_q, 2'b00};
	assign chr_bank_m = chr_banks_q[chr_slot] & chr_bank_mask_q;

	always_comb begin
		mapped_d = '0;
		if (cmd_s1 == CMD_CPU_READ && bus_address_s1[15]) begin
			mapped_d = {prg_bank_m, bus_address_s1[12:0]} & PRG_KEEP;
		end else if (cmd_s1 == CMD_PPU_READ && bus_address_s1[15:13] == 3'd0) begin
			mapped_d = {1'b0, chr_bank_m, bus_address_s1[9:0]} & CHR_KEEP;
		end
	end

	// Scanline counter step on a rising A12
	assign a12_rise = cmd_s1 == CMD_PPU_READ && bus_address_s1[15:13] == 3'd0
		&& bus_address_s1[12] && !prev_a12_q;
	assign counter_next = (irq_counter_q == 8'd0 || reload_request_q) ? irq_reload_q
		: irq_counter_q - 8'd1;

	// Next state for register writes and PPU accesses
	always_comb begin
		chr_banks_d      = chr_banks_q;
		prg_bank_a_d     = prg_bank_a_q;
		prg_bank_b_d     = prg_bank_b_q;
		bank_select_d    = bank_select_q;
		chr_invert_d     = chr_invert_q;
		prg_swap_d       = prg_swap_q;
		irq_counter_d    = irq_counter_q;
		irq_reload_d     = irq_reload_q;
		irq_enable_d     = irq_enable_q;
		reload_request_d = reload_request_q;
		prev_a12_d       = prev_a12_q;
		irq_flag_d       = irq_flag_q;
		mirroring_d      = mirroring_q;
		if (cmd_s1 == CMD_REG_WRITE && bus_address_s1[15]) begin
			case (reg_sel)
				REG_BANK_SELECT: begin
					chr_invert_d  = write_data_s1[7];
					prg_swap_d    = write_data_s1[6];
					bank_select_d = write_data_s1[2:0];
				end
				REG_BANK_DATA: begin
					case (bank_select_q)
						BSEL_CHR_2K_0: begin
							chr_banks_d[0] = write_data_s1 & PAIR_EVEN_MASK;
							chr_banks_d[1] = write_data_s1 | PAIR_ODD_SET;
						end
						BSEL_CHR_2K_1: begin
							chr_banks_d[2] = write_data_s1 & PAIR_EVEN_MASK;
							chr_banks_d[3] = write_data_s1 | PAIR_ODD_SET;
						end
						BSEL_CHR_1K_0: chr_banks_d[4] = write_data_s1;
						BSEL_CHR_1K_1: chr_banks_d[5] = write_data_s1;
						BSEL_CHR_1K_2: chr_banks_d[6] = write_data_s1;
						BSEL_CHR_1K_3: chr_banks_d[7] = write_data_s1;
						BSEL_PRG_A:    prg_bank_a_d   = write_data_s1;
						default:       prg_bank_b_d   = write_data_s1;
					endcase
				end
				REG_MIRRORING: begin
					if (!four_screen_q) begin
						mirroring_d = write_data_s1[0];
					end
				end
				REG_IRQ_LATCH: begin
					irq_reload_d = write_data_s1;
					if (alt_irq_mode_q) begin
						reload_request_d = 1'b1;
					end
				end
				REG_IRQ_CLEAR: irq_counter_d = 8'd0;
				REG_IRQ_DISABLE: begin
					irq_enable_d = 1'b0;
					irq_flag_d   = 1'b0;
				end
				REG_IRQ_ENABLE: irq_enable_d = 1'b1;
				default: ;
			endcase
		end else if (cmd_s1 == CMD_PPU_READ && bus_address_s1[15:13] == 3'd0) begin
			prev_a12_d = bus_address_s1[12];
			if (a12_rise) begin
				irq_counter_d    = counter_next;
				reload_request_d = 1'b0;
				if ((!alt_irq_mode_q || irq_counter_q != 8'd0 || reload_request_q)
					&& counter_next == 8'd0 && irq_enable_q) begin
					irq_flag_d   = 1'b1;
					irq_enable_d = 1'b0;
				end
			end
		end
	end

	// Update mapper state as each item passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_banks_q      <= '{8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0};
			prg_bank_a_q     <= 8'd0;
			prg_bank_b_q     <= 8'd1;
			bank_select_q    <= 3'd0;
			chr_invert_q     <= 1'b0;
			prg_swap_q       <= 1'b0;
			irq_counter_q    <= 8'd0;
			irq_reload_q     <= 8'd255;
			irq_enable_q     <= 1'b0;
			reload_request_q <= 1'b0;
			prev_a12_q       <= 1'b0;
			irq_flag_q       <= 1'b0;
			mirroring_q      <= 1'b0;
		end else if (process) begin
			chr_banks_q      <= chr_banks_d;
			prg_bank_a_q     <= prg_bank_a_d;
			prg_bank_b_q     <= prg_bank_b_d;
			bank_select_q    <= bank_select_d;
			chr_invert_q     <= chr_invert_d;
			prg_swap_q       <= prg_swap_d;
			irq_counter_q    <= irq_counter_d;
			irq_reload_q     <= irq_reload_d;
			irq_enable_q     <= irq_enable_d;
			reload_request_q <= reload_request_d;
			prev_a12_q       <= prev_a12_d;
			irq_flag_q       <= irq_flag_d;
			mirroring_q      <= mirroring_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			mapped_address_s2    <= mapped_d;
			irq_pending_s2       <= irq_flag_d;
			mirror_horizontal_s2 <= mirroring_d;
		end
	end

	// Firing always drops the enable
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_flag_q) |-> !irq_enable_q)
		else $error("irq raised while enable still set");

	// Reload request only arises in the alternate mode
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reload_request_q) |-> $past(alt_irq_mode_q))
		else $error("reload request set outside alternate irq mode");

	// An empty result register never blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ch.ready)
		else $error("input stalled with empty result register");

	// Result reflects the irq flag left by its item
	assert property (@(posedge clk) disable iff (!arst_n)
		process |=> irq_pending_s2 == irq_flag_q)
		else $error("irq_pending differs from irq flag");

endmodule

// ===== sim/bank_mapper_with_scanline_irq_tb.sv =====
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_tb;
	import bmsirq_pkg::*;

	localparam int PRG_BITS    = 19;
	localparam int CHR_BITS    = 18;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_TAIL  = 8;

	// Codes the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]      cmd;
		logic [BUS_ADDR_W-1:0] addr;
		logic [DATA_W-1:0]     data;
	} bus_access_t;

	typedef struct packed {
		logic [MAP_ADDR_W-1:0] mapped;
		logic                  irq;
		logic                  mirror_h;
	} map_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bmsirq_in_if  in_if ();
	bmsirq_out_if out_if ();

	bank_mapper_with_scanline_irq #(
		.PRG_ADDR_BITS(PRG_BITS),
		.CHR_ADDR_BITS(CHR_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mapper state mirror
	logic [5:0] m_prg_mask;
	logic [7:0] m_chr_mask;
	logic       m_alt_irq;
	logic       m_four_screen;
	chr_bank_t  m_chr_banks [8];
	logic [7:0] m_prg_a;
	logic [7:0] m_prg_b;
	logic [2:0] m_bank_sel;
	logic       m_chr_invert;
	logic       m_prg_swap;
	logic [7:0] m_irq_count;
	logic [7:0] m_irq_latch;
	logic       m_irq_en;
	logic       m_reload_req;
	logic       m_last_a12;
	logic       m_irq_flag;
	logic       m_mirror;

	bus_access_t access_q [$];
	map_result_t translated_q [$];
	bus_access_t cur_access;
	map_result_t want;

	int  n_queued = 0;
	int  n_accepted = 0;
	int  n_errors = 0;
	int  stall_cycles = 0;
	int  in_gap = 0;
	int  out_gap = 0;
	int  in_odds = 0;
	int  out_odds = 0;
	logic in_taken = 1'b0;

	task automatic reset_mapper_state();
		m_prg_mask = 6'h3F;
		m_chr_mask = 8'hFF;
		m_alt_irq = 1'b0;
		m_four_screen = 1'b0;
		foreach (m_chr_banks[i])
			m_chr_banks[i] = 8'h00;
		m_chr_banks[1] = 8'h01;
		m_chr_banks[3] = 8'h01;
		m_prg_a = 8'h00;
		m_prg_b = 8'h01;
		m_bank_sel = 3'd0;
		m_chr_invert = 1'b0;
		m_prg_swap = 1'b0;
		m_irq_count = 8'h00;
		m_irq_latch = 8'hFF;
		m_irq_en = 1'b0;
		m_reload_req = 1'b0;
		m_last_a12 = 1'b0;
		m_irq_flag = 1'b0;
		m_mirror = 1'b0;
	endtask

	// Apply one bus access to the mirrored state and return what the mapper shows
	function automatic map_result_t translate_access(input bus_access_t a);
		map_result_t r;
		logic [7:0]  bank;
		logic [2:0]  slot;
		logic [7:0]  old_count;
		logic [31:0] full;
		r = '0;
		bank = '0;
		full = '0;
		case (a.cmd)
			CMD_REG_WRITE: begin
				if (a.addr[15]) begin
					case (a.addr & REG_DECODE_MASK)
						REG_BANK_SELECT: begin
							m_chr_invert = a.data[7];
							m_prg_swap = a.data[6];
							m_bank_sel = a.data[2:0];
						end
						REG_BANK_DATA: begin
							case (m_bank_sel)
								BSEL_CHR_2K_0: begin
									m_chr_banks[0] = a.data & PAIR_EVEN_MASK;
									m_chr_banks[1] = a.data | PAIR_ODD_SET;
								end
								BSEL_CHR_2K_1: begin
									m_chr_banks[2] = a.data & PAIR_EVEN_MASK;
									m_chr_banks[3] = a.data | PAIR_ODD_SET;
								end
								BSEL_CHR_1K_0: m_chr_banks[4] = a.data;
								BSEL_CHR_1K_1: m_chr_banks[5] = a.data;
								BSEL_CHR_1K_2: m_chr_banks[6] = a.data;
								BSEL_CHR_1K_3: m_chr_banks[7] = a.data;
								BSEL_PRG_A:    m_prg_a = a.data;
								default:       m_prg_b = a.data;
							endcase
						end
						REG_MIRRORING: begin
							if (!m_four_screen)
								m_mirror = a.data[0];
						end
						REG_IRQ_LATCH: begin
							m_irq_latch = a.data;
							if (m_alt_irq)
								m_reload_req = 1'b1;
						end
						REG_IRQ_CLEAR: m_irq_count = 8'h00;
						REG_IRQ_DISABLE: begin
							m_irq_en = 1'b0;
							m_irq_flag = 1'b0;
						end
						REG_IRQ_ENABLE: m_irq_en = 1'b1;
						default: ;
					endcase
				end
			end
			CMD_CPU_READ: begin
				if (a.addr[15]) begin
					// Slot 0 and slot 2 trade places when PRG swap is set
					case (a.addr[14:13])
						2'd0: bank = m_prg_swap ? PRG_SECOND_LAST : m_prg_a;
						2'd1: bank = m_prg_b;
						2'd2: bank = m_prg_swap ? m_prg_a : PRG_SECOND_LAST;
						default: bank = PRG_LAST;
					endcase
					bank = bank & {2'b00, m_prg_mask};
					full = ({24'd0, bank} << 13) | {19'd0, a.addr[12:0]};
					full = full & ((32'd1 << PRG_BITS) - 32'd1);
					r.mapped = full[MAP_ADDR_W-1:0];
				end
			end
			CMD_PPU_READ: begin
				if (a.addr < 16'h2000) begin
					// Clock the scanline counter on a rising A12
					if (a.addr[12] && !m_last_a12) begin
						old_count = m_irq_count;
						if (m_irq_count == 8'h00 || m_reload_req)
							m_irq_count = m_irq_latch;
						else
							m_irq_count = m_irq_count - 8'd1;
						if ((!m_alt_irq || old_count != 8'h00 || m_reload_req) &&
								m_irq_count == 8'h00 && m_irq_en) begin
							m_irq_flag = 1'b1;
							m_irq_en = 1'b0;
						end
						m_reload_req = 1'b0;
					end
					m_last_a12 = a.addr[12];
					slot = a.addr[12:10] ^ {m_chr_invert, 2'b00};
					bank = m_chr_banks[slot] & m_chr_mask;
					full = ({24'd0, bank} << 10) | {22'd0, a.addr[9:0]};
					full = full & ((32'd1 << CHR_BITS) - 32'd1);
					r.mapped = full[MAP_ADDR_W-1:0];
				end
			end
			default: ;
		endcase
		r.irq = m_irq_flag;
		r.mirror_h = m_mirror;
		return r;
	endfunction

	// Input side: present queued items, with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken || !in_if.valid) begin
				in_taken = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
					in_if.valid <= 1'b0;
				end else if (in_odds != 0 && $urandom_range(1, in_odds) == 1) begin
					in_gap = $urandom_range(0, 18);
					in_if.valid <= 1'b0;
				end else if (access_q.size() != 0) begin
					cur_access = access_q.pop_front();
					in_if.cmd <= cur_access.cmd;
					in_if.bus_address <= cur_access.addr;
					in_if.write_data <= cur_access.data;
					in_if.valid <= 1'b1;
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// Output side: random stall bursts
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_if.ready <= 1'b0;
		end else if (out_odds != 0 && $urandom_range(1, out_odds) == 1) begin
			out_gap = $urandom_range(0, 18);
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	// Predict on accept, check on result, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (in_if.valid && in_if.ready) begin
				translated_q.push_back(translate_access({in_if.cmd, in_if.bus_address,
					in_if.write_data}));
				in_taken = 1'b1;
				n_accepted++;
			end
			if (out_if.valid && out_if.ready) begin
				if (translated_q.size() == 0) begin
					$error("unexpected result: mapped_address %h", out_if.mapped_address);
					n_errors++;
				end else begin
					want = translated_q.pop_front();
					if (out_if.mapped_address !== want.mapped) begin
						$error("mapped_address: expected %h, got %h", want.mapped,
							out_if.mapped_address);
						n_errors++;
					end
					if (out_if.irq_pending !== want.irq) begin
						$error("irq_pending: expected %b, got %b", want.irq,
							out_if.irq_pending);
						n_errors++;
					end
					if (out_if.mirror_horizontal !== want.mirror_h) begin
						$error("mirror_horizontal: expected %b, got %b", want.mirror_h,
							out_if.mirror_horizontal);
						n_errors++;
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic queue_access(input logic [CMD_W-1:0] cmd, input logic [15:0] addr,
			input logic [7:0] data);
		access_q.push_back({cmd, addr, data});
		n_queued++;
	endtask

	// Register address with random don't-care bits 12:1
	function automatic logic [15:0] reg_address(input logic [15:0] base);
		logic [31:0] rnd;
		rnd = $urandom;
		return base | {3'b000, rnd[11:0], 1'b0};
	endfunction

	task automatic cfg_write(input cfg_index_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_PRG_BANK_MASK: m_prg_mask = value[5:0];
			CFG_CHR_BANK_MASK: m_chr_mask = value;
			CFG_ALT_IRQ_MODE:  m_alt_irq = value[0];
			default:           m_four_screen = value[0];
		endcase
	endtask

	task automatic program_config(input logic [5:0] prg, input logic [7:0] chr,
			input logic alt, input logic four);
		cfg_write(CFG_PRG_BANK_MASK, {2'b00, prg});
		cfg_write(CFG_CHR_BANK_MASK, chr);
		cfg_write(CFG_ALT_IRQ_MODE, {7'd0, alt});
		cfg_write(CFG_FOUR_SCREEN, {7'd0, four});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every queued item is accepted and answered
	task automatic drain();
		while (n_accepted != n_queued || translated_q.size() != 0)
			@(negedge clk);
	endtask

	// Random traffic, mostly scanline runs and bank setups
	task automatic fill_random(input int count);
		int          start;
		int          pairs;
		logic [31:0] rnd;
		logic [7:0]  latch;
		start = n_queued;
		while (n_queued - start < count) begin
			rnd = $urandom;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// Scanline run: arm the counter, then toggle A12
					if ($urandom_range(0, 7) == 0)
						latch = 8'hFF;
					else
						latch = rnd[7:0] % 8'd5;
					queue_access(CMD_REG_WRITE, reg_address(REG_IRQ_LATCH), latch);
					if (rnd[8])
						queue_access(CMD_REG_WRITE, reg_address(REG_IRQ_CLEAR), rnd[23:16]);
					if (rnd[10:9] != 2'b00)
						queue_access(CMD_REG_WRITE, reg_address(REG_IRQ_ENABLE), rnd[31:24]);
					pairs = $urandom_range(2, 10);
					repeat (pairs) begin
						rnd = $urandom;
						queue_access(CMD_PPU_READ, {4'b0000, rnd[11:0]}, rnd[23:16]);
						queue_access(CMD_PPU_READ, {4'b0001, rnd[27:16]}, rnd[7:0]);
						if (rnd[31:29] == 3'b000)
							queue_access(CMD_CPU_READ, rnd[15:0], rnd[23:16]);
					end
					if ($urandom_range(0, 1) == 0)
						queue_access(CMD_REG_WRITE, reg_address(REG_IRQ_DISABLE), rnd[31:24]);
				end
				3, 4: begin
					queue_access(CMD_REG_WRITE, reg_address(REG_BANK_SELECT), rnd[7:0]);
					queue_access(CMD_REG_WRITE, reg_address(REG_BANK_DATA), rnd[15:8]);
				end
				5: queue_access(CMD_REG_WRITE, {1'b1, rnd[14:0]}, rnd[23:16]);
				6: begin
					if (rnd[31:30] != 2'b00)
						queue_access(CMD_CPU_READ, {1'b1, rnd[14:0]}, rnd[23:16]);
					else
						queue_access(CMD_CPU_READ, rnd[15:0], rnd[23:16]);
				end
				7: begin
					if (rnd[31:30] != 2'b00)
						queue_access(CMD_PPU_READ, {3'b000, rnd[12:0]}, rnd[23:16]);
					else
						queue_access(CMD_PPU_READ, rnd[15:0], rnd[23:16]);
				end
				8: queue_access(rnd[25:24], rnd[15:0], rnd[23:16]);
				default: queue_access(CMD_REG_WRITE, reg_address(REG_MIRRORING), rnd[7:0]);
			endcase
		end
	endtask

	initial begin
		logic [31:0] rnd;
		int          phase;
		in_if.valid = 1'b0;
		in_if.cmd = CMD_REG_WRITE;
		in_if.bus_address = '0;
		in_if.write_data = '0;
		out_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PRG_BANK_MASK;
		cfg_data = '0;
		arst_n = 1'b0;
		reset_mapper_state();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: slots, out-of-range addresses, pair forming, counter firing
		in_odds = 6;
		out_odds = 6;
		queue_access(CMD_CPU_READ, 16'h0000, 8'h00);
		queue_access(CMD_CPU_READ, 16'h8000, 8'hFF);
		queue_access(CMD_CPU_READ, 16'hA123, 8'h00);
		queue_access(CMD_CPU_READ, 16'hC000, 8'h00);
		queue_access(CMD_CPU_READ, 16'hFFFF, 8'h00);
		queue_access(CMD_PPU_READ, 16'h1FFF, 8'h00);
		queue_access(CMD_PPU_READ, 16'h2000, 8'h00);
		queue_access(CMD_PPU_READ, 16'hFFFF, 8'h00);
		queue_access(CMD_UNUSED, 16'hFFFF, 8'hFF);
		queue_access(CMD_REG_WRITE, 16'h7FFF, 8'hFF);
		queue_access(CMD_REG_WRITE, 16'hA001, 8'hFF);
		queue_access(CMD_REG_WRITE, REG_BANK_SELECT, 8'hC0);
		queue_access(CMD_REG_WRITE, REG_BANK_DATA, 8'hFF);
		queue_access(CMD_PPU_READ, 16'h0000, 8'h00);
		queue_access(CMD_PPU_READ, 16'h1400, 8'h00);
		queue_access(CMD_REG_WRITE, REG_BANK_SELECT, 8'h07);
		queue_access(CMD_REG_WRITE, REG_BANK_DATA, 8'h00);
		queue_access(CMD_CPU_READ, 16'h8000, 8'h00);
		queue_access(CMD_CPU_READ, 16'hA000, 8'h00);
		queue_access(CMD_REG_WRITE, REG_MIRRORING, 8'h01);
		queue_access(CMD_REG_WRITE, REG_IRQ_LATCH, 8'h00);
		queue_access(CMD_REG_WRITE, REG_IRQ_ENABLE, 8'h00);
		queue_access(CMD_PPU_READ, 16'h1000, 8'h00);
		queue_access(CMD_REG_WRITE, REG_IRQ_DISABLE, 8'h00);
		drain();

		// Random phases under changing configuration; the last runs without idling
		for (phase = 0; phase < 6; phase++) begin
			rnd = $urandom;
			case (phase)
				0: program_config(6'h3F, 8'hFF, 1'b0, 1'b0);
				1: program_config(6'h00, 8'h00, 1'b1, 1'b1);
				2: program_config(rnd[5:0], rnd[15:8], 1'b1, 1'b0);
				3: program_config(6'h3F, 8'hFF, 1'b1, 1'b1);
				4: program_config(rnd[5:0], rnd[15:8], 1'b0, 1'b1);
				default: program_config(rnd[5:0], rnd[15:8], 1'b0, 1'b0);
			endcase
			case (phase)
				0: begin in_odds = 4; out_odds = 4; end
				1: begin in_odds = 0; out_odds = 3; end
				2: begin in_odds = 3; out_odds = 0; end
				3: begin in_odds = 8; out_odds = 8; end
				4: begin in_odds = 2; out_odds = 2; end
				default: begin in_odds = 0; out_odds = 0; end
			endcase
			fill_random(64);
			drain();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
